@@ rtl/alc_pkg.sv @@
// Shared types and constants for the aux memory and language card mapper.
package alc_pkg;

  // Bus access request
  typedef struct packed {
    logic        operation;   // 0 read, 1 write
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  // Mapping result
  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] mapped_address;
    logic [7:0]  read_data;
  } rsp_t;

  // Target codes
  localparam logic [2:0] TGT_RAM  = 3'd0;
  localparam logic [2:0] TGT_ROM  = 3'd1;
  localparam logic [2:0] TGT_IO   = 3'd2;
  localparam logic [2:0] TGT_REG  = 3'd3;
  localparam logic [2:0] TGT_DROP = 3'd4;

  // Answer bytes
  localparam logic [7:0] FLAG_ON   = 8'h80;
  localparam logic [7:0] IDLE_BYTE = 8'hEE;

  // Soft switch addresses
  localparam logic [15:0] SW_80STORE_OFF = 16'hC000;
  localparam logic [15:0] SW_80STORE_ON  = 16'hC001;
  localparam logic [15:0] SW_RAMRD_OFF   = 16'hC002;
  localparam logic [15:0] SW_RAMRD_ON    = 16'hC003;
  localparam logic [15:0] SW_RAMWRT_OFF  = 16'hC004;
  localparam logic [15:0] SW_RAMWRT_ON   = 16'hC005;
  localparam logic [15:0] SW_INTCX_OFF   = 16'hC006;
  localparam logic [15:0] SW_INTCX_ON    = 16'hC007;
  localparam logic [15:0] SW_ALTZP_OFF   = 16'hC008;
  localparam logic [15:0] SW_ALTZP_ON    = 16'hC009;
  localparam logic [15:0] SW_SLOTC3_OFF  = 16'hC00A;
  localparam logic [15:0] SW_SLOTC3_ON   = 16'hC00B;
  localparam logic [15:0] ST_BANK2       = 16'hC011;
  localparam logic [15:0] ST_LCRAM       = 16'hC012;
  localparam logic [15:0] ST_RAMRD       = 16'hC013;
  localparam logic [15:0] ST_RAMWRT      = 16'hC014;
  localparam logic [15:0] ST_INTCX       = 16'hC015;
  localparam logic [15:0] ST_ALTZP       = 16'hC016;
  localparam logic [15:0] ST_SLOTC3      = 16'hC017;
  localparam logic [15:0] ST_80STORE     = 16'hC018;
  localparam logic [15:0] SW_VIDEO       = 16'hC029;
  localparam logic [15:0] SW_PAGE1       = 16'hC054;
  localparam logic [15:0] SW_PAGE2       = 16'hC055;
  localparam logic [15:0] SW_LORES       = 16'hC056;
  localparam logic [15:0] SW_HIRES       = 16'hC057;
  localparam logic [15:0] ROM_LO         = 16'hC071;
  localparam logic [15:0] ROM_HI         = 16'hC07F;
  localparam logic [15:0] LC_LO          = 16'hC080;
  localparam logic [15:0] LC_HI          = 16'hC08F;

  // Page bounds
  localparam logic [7:0] PAGE_IO       = 8'hC0;
  localparam logic [7:0] PAGE_IO_TOP   = 8'hCF;
  localparam logic [7:0] PAGE_LC       = 8'hD0;
  localparam logic [7:0] PAGE_LC_BANK  = 8'hDF;

endpackage

@@ rtl/aux_and_language_card_mapper.sv @@
// Top level: soft switches, language card flip-flops and address mapping.
//
// Takes one CPU bus access per request and returns one mapping result per request. The
// block accepts a request every clock cycle while the result register is empty or being
// read; the result appears in the output register in the cycle after acceptance, and a
// stalled result holds off new requests, so sustained throughput is one access per cycle
// while out_ready stays high. The decode, flag update and address computation form a
// single combinational pass in front of the result register. iolc_enable (cfg_write_en /
// cfg_write_data) resets to 1 and should be changed only while no request is in flight.
module aux_and_language_card_mapper (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic          cfg_write_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  alc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output alc_pkg::rsp_t out_data
);

  logic       iolc_enable;
  logic       store80, aux_read, aux_write, alt_zero_page, page_two;
  logic       hires_mode, internal_cx_rom, slot_c3_rom;
  logic [7:0] video_byte;
  logic       lc_bank_one, lc_read_ram, lc_pre_write, lc_write_inhibit;

  logic       store80_next, aux_read_next, aux_write_next, alt_zero_page_next;
  logic       page_two_next, hires_mode_next, internal_cx_rom_next, slot_c3_rom_next;
  logic [7:0] video_byte_next;
  logic       lc_bank_one_next, lc_read_ram_next, lc_pre_write_next;
  logic       lc_write_inhibit_next;

  alc_pkg::rsp_t rsp_next;
  logic          accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode the request, map the address and work out the new switch state
  always_comb begin
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  page;
    logic        general;
    logic        sel;
    logic        to_ram;
    logic        lc_hit;
    logic [15:0] lc_addr;

    is_write = in_data.operation;
    addr     = in_data.address;
    page     = addr[15:8];

    store80_next          = store80;
    aux_read_next         = aux_read;
    aux_write_next        = aux_write;
    alt_zero_page_next    = alt_zero_page;
    page_two_next         = page_two;
    hires_mode_next       = hires_mode;
    internal_cx_rom_next  = internal_cx_rom;
    slot_c3_rom_next      = slot_c3_rom;
    video_byte_next       = video_byte;
    lc_bank_one_next      = lc_bank_one;
    lc_read_ram_next      = lc_read_ram;
    lc_pre_write_next     = lc_pre_write;
    lc_write_inhibit_next = lc_write_inhibit;

    // Pick the aux bank for RAM targets
    general = is_write ? aux_write : aux_read;
    if (page <= 8'h01 || page >= alc_pkg::PAGE_LC) begin
      sel = alt_zero_page;
    end else if (page >= 8'h04 && page <= 8'h07) begin
      sel = store80 ? page_two : general;
    end else if (page >= 8'h20 && page <= 8'h3F) begin
      sel = (store80 && hires_mode) ? page_two : general;
    end else begin
      sel = general;
    end

    // Lower D0-DF by one 4K bank when bank one is selected
    lc_addr = {addr[15:13], addr[12] & ~(lc_bank_one && page <= alc_pkg::PAGE_LC_BANK),
               addr[11:0]};
    to_ram  = is_write ? !lc_write_inhibit : lc_read_ram;
    lc_hit  = addr inside {[alc_pkg::LC_LO:alc_pkg::LC_HI]};

    rsp_next.target         = alc_pkg::TGT_RAM;
    rsp_next.mapped_address = {sel, addr};
    rsp_next.read_data      = 8'h00;

    if (iolc_enable && page >= alc_pkg::PAGE_IO && page <= alc_pkg::PAGE_IO_TOP) begin
      rsp_next.mapped_address = {1'b0, addr};
      rsp_next.target         = alc_pkg::TGT_IO;
      if (page == alc_pkg::PAGE_IO) begin
        if (is_write) begin
          // Switch writes
          case (addr)
            alc_pkg::SW_80STORE_OFF: store80_next         = 1'b0;
            alc_pkg::SW_80STORE_ON:  store80_next         = 1'b1;
            alc_pkg::SW_RAMRD_OFF:   aux_read_next        = 1'b0;
            alc_pkg::SW_RAMRD_ON:    aux_read_next        = 1'b1;
            alc_pkg::SW_RAMWRT_OFF:  aux_write_next       = 1'b0;
            alc_pkg::SW_RAMWRT_ON:   aux_write_next       = 1'b1;
            alc_pkg::SW_INTCX_OFF:   internal_cx_rom_next = 1'b0;
            alc_pkg::SW_INTCX_ON:    internal_cx_rom_next = 1'b1;
            alc_pkg::SW_ALTZP_OFF:   alt_zero_page_next   = 1'b0;
            alc_pkg::SW_ALTZP_ON:    alt_zero_page_next   = 1'b1;
            alc_pkg::SW_SLOTC3_OFF:  slot_c3_rom_next     = 1'b0;
            alc_pkg::SW_SLOTC3_ON:   slot_c3_rom_next     = 1'b1;
            alc_pkg::SW_VIDEO:       video_byte_next      = in_data.write_data;
            alc_pkg::SW_PAGE1:       page_two_next        = 1'b0;
            alc_pkg::SW_PAGE2:       page_two_next        = 1'b1;
            alc_pkg::SW_LORES:       hires_mode_next      = 1'b0;
            alc_pkg::SW_HIRES:       hires_mode_next      = 1'b1;
            default: ;
          endcase
        end else begin
          // Switch and status reads
          case (addr)
            alc_pkg::ST_BANK2: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = lc_bank_one ? 8'h00 : alc_pkg::FLAG_ON;
            end
            alc_pkg::ST_LCRAM: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = lc_read_ram ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_RAMRD: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = aux_read ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_RAMWRT: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = aux_write ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_INTCX: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = internal_cx_rom ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_ALTZP: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = alt_zero_page ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_SLOTC3: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = slot_c3_rom ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::ST_80STORE: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = store80 ? alc_pkg::FLAG_ON : 8'h00;
            end
            alc_pkg::SW_VIDEO: begin
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = video_byte;
            end
            alc_pkg::SW_PAGE1, alc_pkg::SW_PAGE2: begin
              page_two_next      = addr[0];
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = alc_pkg::IDLE_BYTE;
            end
            alc_pkg::SW_LORES, alc_pkg::SW_HIRES: begin
              hires_mode_next    = addr[0];
              rsp_next.target    = alc_pkg::TGT_REG;
              rsp_next.read_data = alc_pkg::IDLE_BYTE;
            end
            default: begin
              if (lc_hit) begin
                rsp_next.target = alc_pkg::TGT_REG;
              end else if (addr inside {[alc_pkg::ROM_LO:alc_pkg::ROM_HI]}) begin
                rsp_next.target         = alc_pkg::TGT_ROM;
                rsp_next.mapped_address = {1'b1, addr};
              end
            end
          endcase
        end

        // Language card flip-flops
        if (lc_hit) begin
          lc_bank_one_next = addr[3];
          lc_read_ram_next = ~(addr[1] ^ addr[0]);
          if (is_write) begin
            lc_pre_write_next = 1'b0;
          end else begin
            lc_pre_write_next = addr[0];
            if (lc_pre_write && addr[0]) begin
              lc_write_inhibit_next = 1'b0;
            end
          end
          if (!addr[0]) begin
            lc_write_inhibit_next = 1'b1;
          end
        end
      end
    end else if (iolc_enable && page >= alc_pkg::PAGE_LC) begin
      // Language card space
      if (to_ram) begin
        rsp_next.target         = alc_pkg::TGT_RAM;
        rsp_next.mapped_address = {sel, lc_addr};
      end else if (is_write) begin
        rsp_next.target         = alc_pkg::TGT_DROP;
        rsp_next.mapped_address = {1'b0, addr};
      end else begin
        rsp_next.target         = alc_pkg::TGT_ROM;
        rsp_next.mapped_address = {1'b1, addr};
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      iolc_enable <= 1'b1;
    end else if (cfg_write_en) begin
      iolc_enable <= cfg_write_data;
    end
  end

  // Switch state: advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      store80          <= 1'b0;
      aux_read         <= 1'b0;
      aux_write        <= 1'b0;
      alt_zero_page    <= 1'b0;
      page_two         <= 1'b0;
      hires_mode       <= 1'b0;
      internal_cx_rom  <= 1'b0;
      slot_c3_rom      <= 1'b0;
      video_byte       <= 8'h00;
      lc_bank_one      <= 1'b0;
      lc_read_ram      <= 1'b0;
      lc_pre_write     <= 1'b0;
      lc_write_inhibit <= 1'b1;
    end else if (accept) begin
      store80          <= store80_next;
      aux_read         <= aux_read_next;
      aux_write        <= aux_write_next;
      alt_zero_page    <= alt_zero_page_next;
      page_two         <= page_two_next;
      hires_mode       <= hires_mode_next;
      internal_cx_rom  <= internal_cx_rom_next;
      slot_c3_rom      <= slot_c3_rom_next;
      video_byte       <= video_byte_next;
      lc_bank_one      <= lc_bank_one_next;
      lc_read_ram      <= lc_read_ram_next;
      lc_pre_write     <= lc_pre_write_next;
      lc_write_inhibit <= lc_write_inhibit_next;
    end
  end

  // Result register: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp_next;
    end
  end

endmodule

@@ rtl/alc_checker.sv @@
// Port-level checker for the mapper, bound to the top level.
module alc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input alc_pkg::rsp_t out_data
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every accepted request shows a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // Only register answers carry read data
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target != alc_pkg::TGT_REG |-> out_data.read_data == 8'h00)
    else $error("read data outside register target");

  // ROM targets set bit 16 of the mapped address
  a_rom: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target == alc_pkg::TGT_ROM |-> out_data.mapped_address[16])
    else $error("ROM offset missing base");

  // Result register empties on reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aux_and_language_card_mapper alc_checker u_alc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
